/* rtl/core/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted-array priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int PRIO_W   = 32;
  localparam int TAG_W    = 16;
  localparam int OCC_W    = 7;
  localparam int KIND_W   = 2;
  localparam int STAT_W   = 2;

  localparam logic [KIND_W-1:0] KIND_ENQ   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEQ   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic        [TAG_W-1:0]  tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic        [TAG_W-1:0]  tag;
    logic        [OCC_W-1:0]  occupancy;
    logic        [STAT_W-1:0] status;
  } result_t;

endpackage

/* rtl/core/spq_ram.sv */
// ----------------------------------------------------------------------------
// spq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/spq_ctrl.sv */
// ----------------------------------------------------------------------------
// spq_ctrl
// Operation sequencer: fill count, insertion walk with one shared compare,
// and front-entry reads through the store's single read port.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [spq_pkg::KIND_W-1:0]   in_kind,
  input  spq_pkg::entry_t              in_entry,
  output logic                         res_valid,
  input  logic                         res_ready,
  output spq_pkg::result_t             res,
  output logic                         ram_we,
  output logic [spq_pkg::IDX_W-1:0]    ram_waddr,
  output spq_pkg::entry_t              ram_wdata,
  output logic [spq_pkg::IDX_W-1:0]    ram_raddr,
  input  spq_pkg::entry_t              ram_rdata
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_PLACE  = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  localparam logic [spq_pkg::CNT_W-1:0] CNT_FULL = spq_pkg::CNT_W'(spq_pkg::CAPACITY);

  logic [2:0]                       state_r, state_nxt;
  logic [spq_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [spq_pkg::IDX_W-1:0]        pos_r, pos_nxt;
  logic [spq_pkg::KIND_W-1:0]       kind_r, kind_nxt;
  spq_pkg::entry_t                  ent_r, ent_nxt;
  logic signed [spq_pkg::PRIO_W-1:0] rprio_r, rprio_nxt;
  logic [spq_pkg::TAG_W-1:0]        rtag_r, rtag_nxt;
  logic [spq_pkg::STAT_W-1:0]       rstat_r, rstat_nxt;
  logic                             move_up;

  assign move_up = ram_rdata.prio < ent_r.prio;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    kind_nxt  = kind_r;
    ent_nxt   = ent_r;
    rprio_nxt = rprio_r;
    rtag_nxt  = rtag_r;
    rstat_nxt = rstat_r;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = pos_r;
    ram_wdata = ent_r;
    ram_raddr = spq_pkg::IDX_W'(cnt_r - spq_pkg::CNT_W'(1));
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          kind_nxt  = in_kind;
          ent_nxt   = in_entry;
          rprio_nxt = '0;
          rtag_nxt  = '0;
          rstat_nxt = spq_pkg::ST_OK;
          unique case (in_kind)
            spq_pkg::KIND_ENQ: begin
              if (cnt_r == CNT_FULL) begin
                rstat_nxt = spq_pkg::ST_FULL;
                state_nxt = S_RESULT;
              end else if (cnt_r == '0) begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = in_entry;
                cnt_nxt   = cnt_r + spq_pkg::CNT_W'(1);
                state_nxt = S_RESULT;
              end else begin
                pos_nxt   = spq_pkg::IDX_W'(cnt_r);
                state_nxt = S_SHIFT;
              end
            end
            spq_pkg::KIND_DEQ, spq_pkg::KIND_PEEK: begin
              if (cnt_r == '0) begin
                rstat_nxt = spq_pkg::ST_EMPTY;
                state_nxt = S_RESULT;
              end else begin
                state_nxt = S_READ;
              end
            end
            spq_pkg::KIND_CLEAR: begin
              cnt_nxt   = '0;
              state_nxt = S_RESULT;
            end
          endcase
        end
      end
      S_READ: begin
        rprio_nxt = ram_rdata.prio;
        rtag_nxt  = ram_rdata.tag;
        if (kind_r == spq_pkg::KIND_DEQ) begin
          cnt_nxt = cnt_r - spq_pkg::CNT_W'(1);
        end
        state_nxt = S_RESULT;
      end
      S_SHIFT: begin
        ram_we = 1'b1;
        if (move_up) begin
          ram_wdata = ram_rdata;
          pos_nxt   = pos_r - spq_pkg::IDX_W'(1);
          if (pos_r == spq_pkg::IDX_W'(1)) begin
            state_nxt = S_PLACE;
          end else begin
            ram_raddr = pos_r - spq_pkg::IDX_W'(2);
          end
        end else begin
          cnt_nxt   = cnt_r + spq_pkg::CNT_W'(1);
          state_nxt = S_RESULT;
        end
      end
      S_PLACE: begin
        ram_we    = 1'b1;
        cnt_nxt   = cnt_r + spq_pkg::CNT_W'(1);
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res = '{prio: rprio_r, tag: rtag_r,
                 occupancy: spq_pkg::OCC_W'(cnt_r), status: rstat_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    pos_r   <= pos_nxt;
    kind_r  <= kind_nxt;
    ent_r   <= ent_nxt;
    rprio_r <= rprio_nxt;
    rtag_r  <= rtag_nxt;
    rstat_r <= rstat_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("fill count above capacity");

  a_shift_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (pos_r != '0) && (spq_pkg::CNT_W'(pos_r) <= cnt_r))
    else $error("insertion walk out of range");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && rstat_r == spq_pkg::ST_FULL) |-> (cnt_r == CNT_FULL))
    else $error("full reported while not full");

  a_enq_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PLACE) |=> (cnt_r == $past(cnt_r) + spq_pkg::CNT_W'(1)))
    else $error("enqueue did not grow queue");

endmodule

/* rtl/core/sorted_array_priority_queue.sv */
// ----------------------------------------------------------------------------
// sorted_array_priority_queue
// Minimum priority queue held in a sorted RAM; the most urgent entry sits at
// the filled end and leaves first, newest first among equal priorities.
// ----------------------------------------------------------------------------
// One operation is taken at a time over the store's one write and one read port.
// Dequeue and peek read the front entry; clear, rejected operations and an
// enqueue into an empty queue go straight to the result. An enqueue into a
// non-empty queue walks down from the filled end past the more urgent entries,
// one compare and one entry move per cycle; a place step writes it if it
// lands in the least urgent slot. The result sits in an output register, so
// the next transaction can be taken while it waits. No clearing pass runs
// after reset; the fill count marks which entries are live.
module sorted_array_priority_queue (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [spq_pkg::KIND_W-1:0]        in_kind,
  input  logic signed [spq_pkg::PRIO_W-1:0] in_priority_req,
  input  logic [spq_pkg::TAG_W-1:0]         in_tag,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [spq_pkg::PRIO_W-1:0] out_priority,
  output logic [spq_pkg::TAG_W-1:0]         out_tag,
  output logic [spq_pkg::OCC_W-1:0]         out_occupancy,
  output logic [spq_pkg::STAT_W-1:0]        out_status
);

  spq_pkg::entry_t                in_entry;
  spq_pkg::result_t               res;
  spq_pkg::result_t               out_r;
  logic                           res_valid;
  logic                           res_ready;
  logic                           out_valid_r;
  logic                           ram_we;
  logic [spq_pkg::IDX_W-1:0]      ram_waddr;
  logic [spq_pkg::IDX_W-1:0]      ram_raddr;
  spq_pkg::entry_t                ram_wdata;
  spq_pkg::entry_t                ram_rdata;
  logic [spq_pkg::ENTRY_W-1:0]    ram_rdata_raw;

  assign in_entry  = '{prio: in_priority_req, tag: in_tag};
  assign ram_rdata = spq_pkg::entry_t'(ram_rdata_raw);
  assign res_ready = !out_valid_r || out_ready;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_kind   (in_kind),
    .in_entry  (in_entry),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  spq_ram #(
    .WIDTH (spq_pkg::ENTRY_W),
    .DEPTH (spq_pkg::CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_priority  = out_r.prio;
  assign out_tag       = out_r.tag;
  assign out_occupancy = out_r.occupancy;
  assign out_status    = out_r.status;

endmodule
